@@ rtl/core/minhash_sketch_tuples_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the min-hash sketch core
// Shared property wrappers: clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MINHASH_SKETCH_TUPLES_CORE_DEFINES_SVH
`define MINHASH_SKETCH_TUPLES_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MSK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MSK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/msk_pkg.sv @@
// ----------------------------------------------------------------------------
// msk_pkg
// Types, constants and the microcode program of the min-hash sketch core.
// ----------------------------------------------------------------------------
package msk_pkg;

	// Default geometry
	localparam int DESC_BITS_DEF  = 576;
	localparam int NUM_GROUPS_DEF = 20;
	localparam int TUPLE_LEN_DEF  = 3;
	localparam int NUM_PERMS_DEF  = 60;

	// Fixed field widths
	localparam int CMD_W   = 2;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 10;
	localparam int VAL_W   = 10;
	localparam int WIDX_W  = 4;
	localparam int WORD_W  = 64;
	localparam int WBIT_W  = 6;
	localparam int TAG_W   = 16;
	localparam int GROUP_W = 5;
	localparam int MIN_W   = 10;

	// Min-hashes reported per result
	localparam int REPORT_N = 3;
	localparam int J_W      = $clog2(REPORT_N);

	// Request bus packing, lowest bit first
	localparam int S_ROW_LO  = 0;
	localparam int S_COL_LO  = S_ROW_LO + ROW_W;
	localparam int S_VAL_LO  = S_COL_LO + COL_W;
	localparam int S_WIDX_LO = S_VAL_LO + VAL_W;
	localparam int S_WORD_LO = S_WIDX_LO + WIDX_W;
	localparam int S_IMG_LO  = S_WORD_LO + WORD_W;
	localparam int S_PAT_LO  = S_IMG_LO + TAG_W;
	localparam int S_USED_W  = S_PAT_LO + TAG_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

	// Result bus packing, lowest bit first
	localparam int M_USED_W  = GROUP_W + REPORT_N * MIN_W + 2 * TAG_W;
	localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_PERM = 2'd0,
		CMD_LOAD_DESC = 2'd1,
		CMD_COMPUTE   = 2'd2,
		CMD_UNUSED    = 2'd3
	} msk_cmd_t;

	// Datapath actions of one control word
	typedef enum logic [3:0] {
		ACT_NONE  = 4'd0,
		ACT_READY = 4'd1,
		ACT_GINIT = 4'd2,
		ACT_HINIT = 4'd3,
		ACT_SCAN  = 4'd4,
		ACT_SKIP  = 4'd5,
		ACT_NEXTJ = 4'd6,
		ACT_EMIT  = 4'd7,
		ACT_NEXTG = 4'd8,
		ACT_PWR   = 4'd9,
		ACT_DWR   = 4'd10
	} msk_act_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NEVER     = 4'd0,
		C_ALWAYS    = 4'd1,
		C_NO_ACCEPT = 4'd2,
		C_IS_PERM   = 4'd3,
		C_IS_DESC   = 4'd4,
		C_NOT_COMP  = 4'd5,
		C_SKIP      = 4'd6,
		C_SCAN_BUSY = 4'd7,
		C_J_MORE    = 4'd8,
		C_OUT_BUSY  = 4'd9,
		C_G_MORE    = 4'd10
	} msk_cond_t;

	typedef logic [3:0] msk_step_t;

	// Program addresses
	localparam msk_step_t S_FETCH = 4'd0;
	localparam msk_step_t S_DISP0 = 4'd1;
	localparam msk_step_t S_DISP1 = 4'd2;
	localparam msk_step_t S_DISP2 = 4'd3;
	localparam msk_step_t S_GINIT = 4'd4;
	localparam msk_step_t S_HINIT = 4'd5;
	localparam msk_step_t S_SCAN  = 4'd6;
	localparam msk_step_t S_NEXTJ = 4'd7;
	localparam msk_step_t S_EMIT  = 4'd8;
	localparam msk_step_t S_NEXTG = 4'd9;
	localparam msk_step_t S_DONE  = 4'd10;
	localparam msk_step_t S_HSKIP = 4'd11;
	localparam msk_step_t S_PWR   = 4'd12;
	localparam msk_step_t S_DWR   = 4'd13;

	typedef struct packed {
		msk_act_t  act;
		msk_cond_t cond;
		msk_step_t tgt;
	} msk_ucode_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic is_perm;
		logic is_desc;
		logic is_comp;
		logic skip;
		logic scan_done;
		logic j_last;
		logic g_last;
	} msk_dstat_t;

	// Control store
	function automatic msk_ucode_t msk_rom(input msk_step_t s);
		msk_ucode_t w;
		unique case (s)
			S_FETCH: w = '{ACT_READY, C_NO_ACCEPT, S_FETCH};
			S_DISP0: w = '{ACT_NONE,  C_IS_PERM,   S_PWR};
			S_DISP1: w = '{ACT_NONE,  C_IS_DESC,   S_DWR};
			S_DISP2: w = '{ACT_NONE,  C_NOT_COMP,  S_FETCH};
			S_GINIT: w = '{ACT_GINIT, C_NEVER,     S_FETCH};
			S_HINIT: w = '{ACT_HINIT, C_SKIP,      S_HSKIP};
			S_SCAN:  w = '{ACT_SCAN,  C_SCAN_BUSY, S_SCAN};
			S_NEXTJ: w = '{ACT_NEXTJ, C_J_MORE,    S_HINIT};
			S_EMIT:  w = '{ACT_EMIT,  C_OUT_BUSY,  S_EMIT};
			S_NEXTG: w = '{ACT_NEXTG, C_G_MORE,    S_HINIT};
			S_DONE:  w = '{ACT_NONE,  C_ALWAYS,    S_FETCH};
			S_HSKIP: w = '{ACT_SKIP,  C_ALWAYS,    S_NEXTJ};
			S_PWR:   w = '{ACT_PWR,   C_ALWAYS,    S_FETCH};
			S_DWR:   w = '{ACT_DWR,   C_ALWAYS,    S_FETCH};
			default: w = '{ACT_NONE,  C_ALWAYS,    S_FETCH};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/msk_seq.sv @@
// ----------------------------------------------------------------------------
// msk_seq
// Step counter and control store: issues one control word per cycle and
// takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`include "minhash_sketch_tuples_core_defines.svh"

module msk_seq
	import msk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  msk_dstat_t dstat,
	input  logic       accept,
	input  logic       out_free,
	output msk_act_t   act
);

	msk_step_t  step_q;
	msk_ucode_t uc;
	logic       take;

	assign uc  = msk_rom(step_q);
	assign act = uc.act;

	// Evaluate the jump condition
	always_comb begin
		unique case (uc.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ACCEPT: take = !accept;
			C_IS_PERM:   take = dstat.is_perm;
			C_IS_DESC:   take = dstat.is_desc;
			C_NOT_COMP:  take = !dstat.is_comp;
			C_SKIP:      take = dstat.skip;
			C_SCAN_BUSY: take = !dstat.scan_done;
			C_J_MORE:    take = !dstat.j_last;
			C_OUT_BUSY:  take = !out_free;
			C_G_MORE:    take = !dstat.g_last;
			default:     take = 1'b1;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else if (take) begin
			step_q <= uc.tgt;
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

	`MSK_ASSERT_NEXT(a_scan_exit, step_q == S_SCAN, step_q == S_SCAN || step_q == S_NEXTJ, "scan left to an unexpected step")

endmodule

@@ rtl/core/msk_dpath.sv @@
// ----------------------------------------------------------------------------
// msk_dpath
// Request registers, permutation table, descriptor store, scan pipeline and
// the group and tuple counters driven by the control word.
// ----------------------------------------------------------------------------
`include "minhash_sketch_tuples_core_defines.svh"

module msk_dpath
	import msk_pkg::*;
#(
	parameter int DESC_BITS  = DESC_BITS_DEF,
	parameter int NUM_GROUPS = NUM_GROUPS_DEF,
	parameter int TUPLE_LEN  = TUPLE_LEN_DEF,
	parameter int NUM_PERMS  = NUM_PERMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msk_act_t                       act,
	input  logic                           accept,
	input  msk_cmd_t                       cmd,
	input  logic [ROW_W-1:0]               perm_row,
	input  logic [COL_W-1:0]               perm_col,
	input  logic [VAL_W-1:0]               perm_value,
	input  logic [WIDX_W-1:0]              word_index,
	input  logic [WORD_W-1:0]              desc_word,
	input  logic [TAG_W-1:0]               image_id,
	input  logic [TAG_W-1:0]               patch_id,
	output msk_dstat_t                     dstat,
	output logic [GROUP_W-1:0]             group,
	output logic [REPORT_N-1:0][MIN_W-1:0] mins,
	output logic [TAG_W-1:0]               image_tag,
	output logic [TAG_W-1:0]               patch_tag
);

	localparam int DESC_WORDS = (DESC_BITS + WORD_W - 1) / WORD_W;
	localparam int DW_W       = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
	localparam int TBL_DEPTH  = NUM_PERMS * DESC_BITS;
	localparam int ADDR_W     = $clog2(TBL_DEPTH);
	localparam int L_W        = $clog2(DESC_BITS + 1);
	localparam int G_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int P_W        = $clog2(NUM_GROUPS * TUPLE_LEN + REPORT_N + 1);

	// Latched request
	msk_cmd_t          cmd_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [VAL_W-1:0]  val_q;
	logic [WIDX_W-1:0] widx_q;
	logic [WORD_W-1:0] word_q;
	logic [TAG_W-1:0]  img_q;
	logic [TAG_W-1:0]  pat_q;

	// Storage
	logic [VAL_W-1:0]  perm_mem [TBL_DEPTH];
	logic [WORD_W-1:0] desc_q [DESC_WORDS];

	// Counters and scan pipeline
	logic [G_W-1:0]    g_q;
	logic [P_W-1:0]    pg_q;
	logic [J_W-1:0]    j_q;
	logic [P_W-1:0]    p;
	logic [ADDR_W-1:0] addr_q;
	logic [L_W-1:0]    lcnt_q;
	logic              tv_s1;
	logic [L_W-1:0]    l_s1;
	logic [VAL_W-1:0]  rd_s1;
	logic [L_W-1:0]    m_q [REPORT_N];

	logic              pwr_ok;
	logic [ADDR_W-1:0] waddr;
	logic              in_rng;
	logic              hit;
	logic              scan_done;
	logic [L_W-1:0]    result;

	// Hold the request on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			row_q  <= perm_row;
			col_q  <= perm_col;
			val_q  <= perm_value;
			widx_q <= word_index;
			word_q <= desc_word;
			img_q  <= image_id;
			pat_q  <= patch_id;
		end
	end

	// Table write address and range check
	assign pwr_ok = (32'(row_q) < NUM_PERMS) && (32'(col_q) < DESC_BITS);
	assign waddr  = ADDR_W'(32'(row_q) * DESC_BITS + 32'(col_q));

	// Permutation table: up to one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (act == ACT_PWR && pwr_ok) begin
			perm_mem[waddr] <= val_q;
		end
		rd_s1 <= perm_mem[addr_q];
	end

	// Descriptor words, out-of-range words dropped
	always_ff @(posedge clk) begin
		if (act == ACT_DWR && 32'(widx_q) < DESC_WORDS) begin
			desc_q[widx_q[DW_W-1:0]] <= word_q;
		end
	end

	// Current permutation number
	assign p = pg_q + P_W'(j_q);

	// Test the entry read last cycle
	assign in_rng    = 32'(rd_s1) < DESC_BITS;
	assign hit       = tv_s1 && in_rng && desc_q[rd_s1[WBIT_W +: DW_W]][rd_s1[WBIT_W-1:0]];
	assign scan_done = hit || (tv_s1 && l_s1 == L_W'(DESC_BITS - 1));
	assign result    = hit ? l_s1 : L_W'(DESC_BITS);

	// Counters and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q    <= '0;
			pg_q   <= '0;
			j_q    <= '0;
			lcnt_q <= '0;
			tv_s1  <= 1'b0;
		end else begin
			case (act)
				ACT_GINIT: begin
					g_q  <= '0;
					pg_q <= '0;
					j_q  <= '0;
				end
				ACT_HINIT: begin
					lcnt_q <= '0;
					tv_s1  <= 1'b0;
				end
				ACT_SCAN: begin
					if (lcnt_q != L_W'(DESC_BITS)) begin
						lcnt_q <= lcnt_q + 1'b1;
						tv_s1  <= 1'b1;
					end else begin
						tv_s1 <= 1'b0;
					end
				end
				ACT_NEXTJ: begin
					j_q <= j_q + 1'b1;
				end
				ACT_NEXTG: begin
					g_q  <= g_q + 1'b1;
					pg_q <= pg_q + P_W'(TUPLE_LEN);
					j_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Address, position and min-hash registers
	always_ff @(posedge clk) begin
		case (act)
			ACT_HINIT: begin
				addr_q <= ADDR_W'(32'(p) * DESC_BITS);
			end
			ACT_SCAN: begin
				if (lcnt_q != L_W'(DESC_BITS)) begin
					addr_q <= addr_q + 1'b1;
					l_s1   <= lcnt_q;
				end
				if (scan_done) begin
					m_q[j_q] <= result;
				end
			end
			ACT_SKIP: begin
				m_q[j_q] <= L_W'(DESC_BITS);
			end
			default: begin
			end
		endcase
	end

	// Status to the sequencer
	assign dstat.is_perm   = cmd_q == CMD_LOAD_PERM;
	assign dstat.is_desc   = cmd_q == CMD_LOAD_DESC;
	assign dstat.is_comp   = cmd_q == CMD_COMPUTE;
	assign dstat.skip      = (32'(j_q) >= TUPLE_LEN) || (32'(p) >= NUM_PERMS);
	assign dstat.scan_done = scan_done;
	assign dstat.j_last    = j_q == J_W'(REPORT_N - 1);
	assign dstat.g_last    = g_q == G_W'(NUM_GROUPS - 1);

	// Result fields
	assign group     = GROUP_W'(g_q);
	assign image_tag = img_q;
	assign patch_tag = pat_q;

	generate
		for (genvar i = 0; i < REPORT_N; i++) begin : g_mins
			assign mins[i] = MIN_W'(m_q[i]);
		end
	endgenerate

	`MSK_ASSERT_NOW(a_pos_range, tv_s1, l_s1 < L_W'(DESC_BITS), "scan position beyond descriptor")

endmodule

@@ rtl/core/minhash_sketch_tuples_core.sv @@
// ----------------------------------------------------------------------------
// minhash_sketch_tuples_core
// Load requests write one table entry or one descriptor word each. A compute
// request is paced by the table scan, one table read per cycle, and by any
// result back-pressure; no request is accepted until the last one is done.
// Each scan stops at the first set bit; results leave through an output
// register. Reset clears the step counter, the scan counters and valid flags;
// table and descriptor hold undefined data until loaded.
// ----------------------------------------------------------------------------
`include "minhash_sketch_tuples_core_defines.svh"

module minhash_sketch_tuples_core
	import msk_pkg::*;
#(
	parameter int DESC_BITS  = DESC_BITS_DEF,
	parameter int NUM_GROUPS = NUM_GROUPS_DEF,
	parameter int TUPLE_LEN  = TUPLE_LEN_DEF,
	parameter int NUM_PERMS  = NUM_PERMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// perm_row, perm_col, perm_value, word_index, desc_word, image_id, patch_id
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [CMD_W-1:0]     s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// group, min_first, min_second, min_third, image_tag, patch_tag
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	msk_act_t                       act;
	msk_dstat_t                     dstat;
	logic                           accept;
	logic                           out_free;
	logic                           ld_out;
	logic [GROUP_W-1:0]             group;
	logic [REPORT_N-1:0][MIN_W-1:0] mins;
	logic [TAG_W-1:0]               image_tag;
	logic [TAG_W-1:0]               patch_tag;

	logic                           out_vld_q;
	logic [M_TDATA_W-1:0]           out_data_q;
	logic                           out_last_q;

	// Request handshake
	assign s_tready = act == ACT_READY;
	assign accept   = s_tvalid && s_tready;

	msk_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.dstat    (dstat),
		.accept   (accept),
		.out_free (out_free),
		.act      (act)
	);

	msk_dpath #(
		.DESC_BITS  (DESC_BITS),
		.NUM_GROUPS (NUM_GROUPS),
		.TUPLE_LEN  (TUPLE_LEN),
		.NUM_PERMS  (NUM_PERMS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.accept     (accept),
		.cmd        (msk_cmd_t'(s_tuser)),
		.perm_row   (s_tdata[S_ROW_LO +: ROW_W]),
		.perm_col   (s_tdata[S_COL_LO +: COL_W]),
		.perm_value (s_tdata[S_VAL_LO +: VAL_W]),
		.word_index (s_tdata[S_WIDX_LO +: WIDX_W]),
		.desc_word  (s_tdata[S_WORD_LO +: WORD_W]),
		.image_id   (s_tdata[S_IMG_LO +: TAG_W]),
		.patch_id   (s_tdata[S_PAT_LO +: TAG_W]),
		.dstat      (dstat),
		.group      (group),
		.mins       (mins),
		.image_tag  (image_tag),
		.patch_tag  (patch_tag)
	);

	// Output register is free when empty or being drained
	assign out_free = !out_vld_q || m_tready;
	assign ld_out   = (act == ACT_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Pack the result on load
	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_data_q <= {{M_PAD_W{1'b0}}, patch_tag, image_tag, mins, group};
			out_last_q <= dstat.g_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`MSK_ASSERT_NEXT(a_fetch_once, accept, act != ACT_READY, "second request taken without processing the first")
	`MSK_ASSERT_NOW(a_last_group, out_vld_q && out_last_q, out_data_q[GROUP_W-1:0] == GROUP_W'(NUM_GROUPS - 1), "last flag on a group other than the final one")

endmodule
